// ----- rtl/core/hti_pkg.sv -----
// shared types, constants and divider step functions for the heightfield interpolator
// no dependencies; used by every module under rtl/core except hti_ram
`default_nettype none

package hti_pkg;

  localparam int ADDR_W      = 16;
  localparam int MEM_DEPTH   = 65536;
  localparam int HGT_W       = 16;
  localparam int DIM_W       = 9;
  localparam int SP_W        = 11;
  localparam int OFS_W       = 19;
  localparam int MAX_DIM     = 256;

  localparam int CELL_STAGES = 4;
  localparam int CELL_STEPS  = 4;
  localparam int NORM_STAGES = 5;
  localparam int NORM_STEPS  = 4;
  localparam int NORM_BITS   = 19;

  localparam int CMD_WRITE   = 0;
  localparam int CMD_QUERY   = 1;

  localparam logic [1:0] REG_COLS    = 2'd0;
  localparam logic [1:0] REG_ROWS    = 2'd1;
  localparam logic [1:0] REG_SPACING = 2'd2;

  typedef struct packed {
    logic [SP_W-1:0] rem;
    logic [15:0]     nq;
  } div16_t;

  typedef struct packed {
    logic [SP_W-1:0]      rem;
    logic [NORM_BITS-1:0] nq;
  } div19_t;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [ADDR_W-1:0] idx;
    logic [HGT_W-1:0]  hval;
    logic [7:0]        xl;
    logic [7:0]        zl;
    logic [DIM_W-1:0]  cols;
    logic [DIM_W-1:0]  rows;
    logic [SP_W-1:0]   sp;
    div16_t            dx;
    div16_t            dz;
  } front_t;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [ADDR_W-1:0] idx;
    logic [HGT_W-1:0]  hval;
    logic              oor;
    logic [ADDR_W-1:0] base;
    logic [DIM_W-1:0]  cols;
    logic [OFS_W-1:0]  rx;
    logic [OFS_W-1:0]  rz;
    logic [SP_W-1:0]   sp;
  } loc_t;

  typedef struct packed {
    logic                    valid;
    logic                    oor;
    logic [OFS_W-1:0]        rx;
    logic [OFS_W-1:0]        rz;
    logic [SP_W-1:0]         sp;
    logic signed [HGT_W-1:0] ha;
    logic signed [HGT_W-1:0] hb;
    logic signed [HGT_W-1:0] hc;
    logic signed [HGT_W-1:0] hd;
  } fetch_t;

  // one restoring step: shift in the next dividend bit, quotient bit lands at the bottom
  function automatic div16_t div16_step(div16_t v, logic [SP_W-1:0] d);
    logic [SP_W:0] t;
    div16_t        r;
    t    = {v.rem, v.nq[15]};
    r.nq = {v.nq[14:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem   = SP_W'(t - {1'b0, d});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = t[SP_W-1:0];
    end
    return r;
  endfunction

  function automatic div19_t div19_step(div19_t v, logic [SP_W-1:0] d);
    logic [SP_W:0] t;
    div19_t        r;
    t    = {v.rem, v.nq[NORM_BITS-1]};
    r.nq = {v.nq[NORM_BITS-2:0], 1'b0};
    if (t >= {1'b0, d}) begin
      r.rem   = SP_W'(t - {1'b0, d});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = t[SP_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hti_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module hti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hti_locate.sv -----
// input capture, pipelined cell division and corner address calculation
// depends on hti_pkg
`default_nettype none

module hti_locate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_cmd_i,
  input  wire logic [hti_pkg::ADDR_W-1:0]    in_idx_i,
  input  wire logic [hti_pkg::HGT_W-1:0]     in_hval_i,
  input  wire logic [23:0]                   in_x_i,
  input  wire logic [23:0]                   in_z_i,
  input  wire logic [hti_pkg::DIM_W-1:0]     cfg_cols_i,
  input  wire logic [hti_pkg::DIM_W-1:0]     cfg_rows_i,
  input  wire logic [hti_pkg::SP_W-1:0]      cfg_sp_i,
  output hti_pkg::loc_t                      loc_o
);

  localparam int NST = hti_pkg::CELL_STAGES + 1;

  hti_pkg::front_t st_q [NST];
  hti_pkg::front_t st_d [NST];
  hti_pkg::loc_t   loc_q, loc_d;

  logic [hti_pkg::DIM_W-1:0] cols_c, rows_c;

  always_comb begin
    if (cfg_cols_i < hti_pkg::DIM_W'(2)) cols_c = hti_pkg::DIM_W'(2);
    else if (cfg_cols_i > hti_pkg::DIM_W'(hti_pkg::MAX_DIM)) cols_c = hti_pkg::DIM_W'(hti_pkg::MAX_DIM);
    else cols_c = cfg_cols_i;
    if (cfg_rows_i < hti_pkg::DIM_W'(2)) rows_c = hti_pkg::DIM_W'(2);
    else if (cfg_rows_i > hti_pkg::DIM_W'(hti_pkg::MAX_DIM)) rows_c = hti_pkg::DIM_W'(hti_pkg::MAX_DIM);
    else rows_c = cfg_rows_i;
  end

  always_comb begin
    st_d[0].valid  = in_valid_i;
    st_d[0].cmd    = in_cmd_i;
    st_d[0].idx    = in_idx_i;
    st_d[0].hval   = in_hval_i;
    st_d[0].xl     = in_x_i[7:0];
    st_d[0].zl     = in_z_i[7:0];
    st_d[0].cols   = cols_c;
    st_d[0].rows   = rows_c;
    st_d[0].sp     = (cfg_sp_i == '0) ? hti_pkg::SP_W'(1) : cfg_sp_i;
    // integer part of the position divided by spacing, fraction byte rides along
    st_d[0].dx.rem = '0;
    st_d[0].dx.nq  = in_x_i[23:8];
    st_d[0].dz.rem = '0;
    st_d[0].dz.nq  = in_z_i[23:8];
    for (int k = 1; k < NST; k++) begin
      st_d[k] = st_q[k-1];
      for (int j = 0; j < hti_pkg::CELL_STEPS; j++) begin
        st_d[k].dx = hti_pkg::div16_step(st_d[k].dx, st_q[k-1].sp);
        st_d[k].dz = hti_pkg::div16_step(st_d[k].dz, st_q[k-1].sp);
      end
    end
  end

  logic [15:0]                 col_w, row_w;
  logic [hti_pkg::OFS_W-1:0]   s_w, rzm_w;
  logic [16:0]                 prod_w;

  always_comb begin
    col_w  = st_q[NST-1].dx.nq;
    row_w  = st_q[NST-1].dz.nq;
    s_w    = {st_q[NST-1].sp, 8'd0};
    rzm_w  = {st_q[NST-1].dz.rem, st_q[NST-1].zl};
    prod_w = 17'(row_w[7:0] * st_q[NST-1].cols);

    loc_d.valid = st_q[NST-1].valid;
    loc_d.cmd   = st_q[NST-1].cmd;
    loc_d.idx   = st_q[NST-1].idx;
    loc_d.hval  = st_q[NST-1].hval;
    loc_d.oor   = (col_w >= 16'({7'd0, st_q[NST-1].cols} - 16'd1)) ||
                  (row_w >= 16'({7'd0, st_q[NST-1].rows} - 16'd1));
    loc_d.base  = hti_pkg::ADDR_W'(prod_w[15:0] + {8'd0, col_w[7:0]});
    loc_d.cols  = st_q[NST-1].cols;
    loc_d.rx    = {st_q[NST-1].dx.rem, st_q[NST-1].xl};
    loc_d.rz    = hti_pkg::OFS_W'(s_w - rzm_w);
    loc_d.sp    = st_q[NST-1].sp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) st_q[k].valid <= 1'b0;
      loc_q.valid <= 1'b0;
    end else if (adv_i) begin
      for (int k = 0; k < NST; k++) st_q[k] <= st_d[k];
      loc_q <= loc_d;
    end
  end

  assign loc_o = loc_q;

endmodule

`default_nettype wire

// ----- rtl/core/hti_fetch.sv -----
// height store: four copies read all four corners in the same cycle, plus the clearing pass
// depends on hti_pkg and hti_ram
`default_nettype none

module hti_fetch (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire hti_pkg::loc_t loc_i,
  output logic               clearing_o,
  output hti_pkg::fetch_t    fch_o
);

  localparam int AW = hti_pkg::ADDR_W;

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  hti_pkg::loc_t meta_q, meta_d;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [hti_pkg::HGT_W-1:0]  wdata;
  logic [AW-1:0]              ad_a, ad_b, ad_c, ad_d;
  logic [hti_pkg::HGT_W-1:0]  rd_a, rd_b, rd_c, rd_d;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + AW'(1);
      if (clr_cnt_q == {AW{1'b1}}) clr_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // writes happen at the read stage so a later query sees them
  assign we    = clr_q || (adv_i && loc_i.valid && (loc_i.cmd == 1'(hti_pkg::CMD_WRITE)));
  assign waddr = clr_q ? clr_cnt_q : loc_i.idx;
  assign wdata = clr_q ? '0 : loc_i.hval;

  assign ad_d = loc_i.base;
  assign ad_c = AW'(loc_i.base + AW'(1));
  assign ad_a = AW'(loc_i.base + {7'd0, loc_i.cols});
  assign ad_b = AW'(loc_i.base + {7'd0, loc_i.cols} + AW'(1));

  hti_ram #(.WIDTH(hti_pkg::HGT_W), .DEPTH(hti_pkg::MEM_DEPTH)) u_ram_a (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(adv_i), .raddr_i(ad_a), .rdata_o(rd_a)
  );
  hti_ram #(.WIDTH(hti_pkg::HGT_W), .DEPTH(hti_pkg::MEM_DEPTH)) u_ram_b (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(adv_i), .raddr_i(ad_b), .rdata_o(rd_b)
  );
  hti_ram #(.WIDTH(hti_pkg::HGT_W), .DEPTH(hti_pkg::MEM_DEPTH)) u_ram_c (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(adv_i), .raddr_i(ad_c), .rdata_o(rd_c)
  );
  hti_ram #(.WIDTH(hti_pkg::HGT_W), .DEPTH(hti_pkg::MEM_DEPTH)) u_ram_d (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .re_i(adv_i), .raddr_i(ad_d), .rdata_o(rd_d)
  );

  always_comb begin
    meta_d       = loc_i;
    // write items end here
    meta_d.valid = loc_i.valid && (loc_i.cmd == 1'(hti_pkg::CMD_QUERY));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q.valid <= 1'b0;
    end else if (adv_i) begin
      meta_q <= meta_d;
    end
  end

  always_comb begin
    fch_o.valid = meta_q.valid;
    fch_o.oor   = meta_q.oor;
    fch_o.rx    = meta_q.rx;
    fch_o.rz    = meta_q.rz;
    fch_o.sp    = meta_q.sp;
    fch_o.ha    = $signed(rd_a);
    fch_o.hb    = $signed(rd_b);
    fch_o.hc    = $signed(rd_c);
    fch_o.hd    = $signed(rd_d);
  end

  assign clearing_o = clr_q;

endmodule

`default_nettype wire

// ----- rtl/core/hti_blend.sv -----
// triangle select, weighted sum, rounding divide by the cell size and saturation
// depends on hti_pkg
`default_nettype none

module hti_blend (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        adv_i,
  input  wire hti_pkg::fetch_t             fch_i,
  output logic                             res_valid_o,
  output logic [hti_pkg::HGT_W-1:0]        res_height_o,
  output logic                             res_oor_o
);

  localparam int OW = hti_pkg::OFS_W;
  localparam int SW = hti_pkg::SP_W;
  localparam int NB = hti_pkg::NORM_BITS;
  localparam int NS = hti_pkg::NORM_STAGES;

  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [SW-1:0]      sp;
    logic [OW-1:0]      s;
    logic signed [15:0] a;
    logic signed [16:0] e1;
    logic signed [16:0] e2;
    logic [OW-1:0]      r1;
    logic [OW-1:0]      r2;
  } b1_t;

  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [SW-1:0]      sp;
    logic [OW-1:0]      s;
    logic signed [36:0] p0;
    logic signed [36:0] p1;
    logic signed [36:0] p2;
  } b2_t;

  typedef struct packed {
    logic               valid;
    logic               oor;
    logic [SW-1:0]      sp;
    logic [OW-1:0]      s;
    logic signed [39:0] sum;
  } b3_t;

  typedef struct packed {
    logic           valid;
    logic           oor;
    logic [SW-1:0]  sp;
    hti_pkg::div19_t v;
  } bd_t;

  b1_t b1_q, b1_d;
  b2_t b2_q, b2_d;
  b3_t b3_q, b3_d;
  bd_t bd_q [NS+1];
  bd_t bd_d [NS+1];

  logic                 out_valid_q;
  logic [15:0]          out_h_q, out_h_d;
  logic                 out_oor_q;

  always_comb begin
    b1_d.valid = fch_i.valid;
    b1_d.oor   = fch_i.oor;
    b1_d.sp    = fch_i.sp;
    b1_d.s     = {fch_i.sp, 8'd0};
    b1_d.a     = fch_i.ha;
    // upper triangle when the x offset passes the z offset
    if (fch_i.rx > fch_i.rz) begin
      b1_d.e1 = 17'(fch_i.hb) - 17'(fch_i.ha);
      b1_d.r1 = fch_i.rx;
      b1_d.e2 = 17'(fch_i.hc) - 17'(fch_i.hb);
      b1_d.r2 = fch_i.rz;
    end else begin
      b1_d.e1 = 17'(fch_i.hd) - 17'(fch_i.ha);
      b1_d.r1 = fch_i.rz;
      b1_d.e2 = 17'(fch_i.hc) - 17'(fch_i.hd);
      b1_d.r2 = fch_i.rx;
    end
  end

  always_comb begin
    b2_d.valid = b1_q.valid;
    b2_d.oor   = b1_q.oor;
    b2_d.sp    = b1_q.sp;
    b2_d.s     = b1_q.s;
    b2_d.p0    = 37'(b1_q.a) * 37'($signed({1'b0, b1_q.s}));
    b2_d.p1    = 37'(b1_q.e1) * 37'($signed({1'b0, b1_q.r1}));
    b2_d.p2    = 37'(b1_q.e2) * 37'($signed({1'b0, b1_q.r2}));
  end

  always_comb begin
    b3_d.valid = b2_q.valid;
    b3_d.oor   = b2_q.oor;
    b3_d.sp    = b2_q.sp;
    b3_d.s     = b2_q.s;
    b3_d.sum   = 40'(b2_q.p0) + 40'(b2_q.p1) + 40'(b2_q.p2);
  end

  logic signed [40:0] num_w;
  logic signed [32:0] nn_w, np_w;

  always_comb begin
    // floor((2*sum + s) / (512*sp)): shift out the 512, bias positive, divide by sp
    num_w = $signed({b3_q.sum, 1'b0}) + $signed({22'd0, b3_q.s});
    nn_w  = 33'(num_w >>> 9);
    np_w  = nn_w + $signed({4'd0, b3_q.sp, 18'd0});
    bd_d[0].valid  = b3_q.valid;
    bd_d[0].oor    = b3_q.oor;
    bd_d[0].sp     = b3_q.sp;
    bd_d[0].v.rem  = np_w[29:NB];
    bd_d[0].v.nq   = np_w[NB-1:0];
    for (int k = 1; k <= NS; k++) begin
      bd_d[k] = bd_q[k-1];
      for (int j = 0; j < hti_pkg::NORM_STEPS; j++) begin
        if ((k - 1) * hti_pkg::NORM_STEPS + j < NB) begin
          bd_d[k].v = hti_pkg::div19_step(bd_d[k].v, bd_q[k-1].sp);
        end
      end
    end
  end

  logic signed [NB:0] q_w;

  always_comb begin
    q_w = $signed({1'b0, bd_q[NS].v.nq}) - $signed((NB+1)'(1) <<< 18);
    if (bd_q[NS].oor) out_h_d = '0;
    else if (q_w > (NB+1)'(32767)) out_h_d = 16'h7fff;
    else if (q_w < -(NB+1)'(32768)) out_h_d = 16'h8000;
    else out_h_d = q_w[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_q.valid <= 1'b0;
      b2_q.valid <= 1'b0;
      b3_q.valid <= 1'b0;
      for (int k = 0; k <= NS; k++) bd_q[k].valid <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      for (int k = 0; k <= NS; k++) bd_q[k] <= bd_d[k];
      out_valid_q <= bd_q[NS].valid;
      out_h_q     <= out_h_d;
      out_oor_q   <= bd_q[NS].oor;
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_height_o = out_h_q;
  assign res_oor_o    = out_oor_q;

endmodule

`default_nettype wire

// ----- rtl/core/heightfield_triangle_interpolator_top.sv -----
// heightfield triangle interpolator: one item per cycle through 17 register stages
// throughput is set by the single stall signal shared by all stages: a stalled
// output holds every stage, otherwise a new item can enter each cycle outside the clearing pass
// after reset a clearing pass writes zero to all 65536 heights with s_axis_tready
// low; configuration writes are taken during the pass
// depends on hti_pkg, hti_locate, hti_fetch, hti_blend
`default_nettype none

module heightfield_triangle_interpolator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // vertex_index, height_value, x_pos, z_pos
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // height_out
  output logic             m_axis_tuser,  // out_of_range
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [hti_pkg::DIM_W-1:0] cols_q, rows_q;
  logic [hti_pkg::SP_W-1:0]  sp_q;
  logic                      cfg_we;
  logic                      adv, clearing;
  hti_pkg::loc_t             loc;
  hti_pkg::fetch_t           fch;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= hti_pkg::DIM_W'(128);
      rows_q <= hti_pkg::DIM_W'(128);
      sp_q   <= hti_pkg::SP_W'(1);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        hti_pkg::REG_COLS:    cols_q <= pwdata[hti_pkg::DIM_W-1:0];
        hti_pkg::REG_ROWS:    rows_q <= pwdata[hti_pkg::DIM_W-1:0];
        hti_pkg::REG_SPACING: sp_q   <= pwdata[hti_pkg::SP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hti_pkg::REG_COLS:    prdata = {23'd0, cols_q};
      hti_pkg::REG_ROWS:    prdata = {23'd0, rows_q};
      hti_pkg::REG_SPACING: prdata = {21'd0, sp_q};
      default:              prdata = '0;
    endcase
  end

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !clearing;

  hti_locate u_locate (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .in_valid_i (s_axis_tvalid && s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_idx_i   (s_axis_tdata[15:0]),
    .in_hval_i  (s_axis_tdata[31:16]),
    .in_x_i     (s_axis_tdata[55:32]),
    .in_z_i     (s_axis_tdata[79:56]),
    .cfg_cols_i (cols_q),
    .cfg_rows_i (rows_q),
    .cfg_sp_i   (sp_q),
    .loc_o      (loc)
  );

  hti_fetch u_fetch (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .loc_i      (loc),
    .clearing_o (clearing),
    .fch_o      (fch)
  );

  hti_blend u_blend (
    .clk_i,
    .rst_ni,
    .adv_i        (adv),
    .fch_i        (fch),
    .res_valid_o  (m_axis_tvalid),
    .res_height_o (m_axis_tdata),
    .res_oor_o    (m_axis_tuser)
  );

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("out of range result with nonzero height");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s_axis_tready)
    else $error("item accepted during clearing pass");

  a_clear_ends_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing |=> !clearing)
    else $error("clearing pass restarted");

endmodule

`default_nettype wire
